[rtl/core/spdinv_pkg.sv]
// spdinv_pkg: shared types and constants of the spd matrix inverse unit
// fsm states, datapath command and status structs, operand selects
// no dependencies
`timescale 1ns / 1ps

package spdinv_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int SIZE_W = 4;
    localparam int SLOT_W = 6;
    localparam int SLOTS  = 64;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_START, ST_F_RD, ST_F_MUL, ST_F_ACC, ST_F_DEN, ST_F_NUM, ST_F_CHK, ST_F_WAIT,
        ST_V_START, ST_V_RD, ST_V_MUL, ST_V_ACC, ST_V_DEN, ST_V_NUM, ST_V_CHK, ST_V_WAIT,
        ST_O_START, ST_O_RD, ST_O_MUL, ST_O_ACC, ST_O_EMIT
    } state_t;

    // multiplier operand pairs
    typedef enum logic [1:0] {
        MUL_LL,     // factor x factor
        MUL_LI,     // factor x inverse factor
        MUL_II      // inverse factor x inverse factor
    } mul_sel_t;

    // numerator source for the divide / root unit
    typedef enum logic [1:0] {
        NUM_DIFF,   // loaded element minus accumulator
        NUM_ACC,    // accumulator
        NUM_ONE     // fixed-point one
    } num_sel_t;

    typedef struct packed {
        logic               load_we;
        logic               acc_clr;
        logic               mul_en;
        mul_sel_t           mul_sel;
        logic               acc_add;
        logic               acc_sub;
        logic               num_en;
        num_sel_t           num_sel;
        logic               sqrt_start;
        logic               div_start;
        logic               l_we;
        logic               linv_we;
        logic               out_load;
        logic [IDX_W-1:0]   out_row;
        logic [IDX_W-1:0]   out_col;
        logic               out_last;
        logic               out_err;
    } dp_cmd_t;

    typedef struct packed {
        logic unit_busy;
        logic num_nonpos;
        logic out_full;
    } dp_stat_t;

endpackage

[rtl/core/spd_matrix_inverse_unit.sv]
// spd_matrix_inverse_unit: top level of the cholesky based spd matrix inverse
// holds the size register and joins the sequencer to the datapath
// depends on spdinv_pkg, spdinv_ctrl, spdinv_dpath
`timescale 1ns / 1ps

// Elements of an n x n symmetric positive-definite matrix load row-major, one per
// cycle, in signed fixed point with FRAC_BITS fraction bits; the transaction with
// s_tlast set starts the run. The unit factors the matrix by Cholesky, inverts the
// factor by forward substitution and forms the inverse as Linv^T * Linv, then
// emits n*n results row-major with m_tlast on the final one. Every product and
// every step of each loop goes through one multiplier and one accumulator, and
// every pivot root and quotient goes through one shared iterative unit. New
// elements are taken only between runs.
// A non-positive pivot ends the run early with zero values and m_tuser set.

module spd_matrix_inverse_unit #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // size register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    // element input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // element_value
    input  logic        s_tlast,    // is_last
    // inverse output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // row_index[2:0], col_index[5:3], inverse_value[37:6]
    output logic        m_tlast,    // last_result
    output logic        m_tuser     // not_positive_definite
);

    localparam int LA_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    logic [3:0]                 matrix_size_reg, matrix_size_next;
    spdinv_pkg::dp_cmd_t        cmd;
    spdinv_pkg::dp_stat_t       stat;
    logic [5:0]                 in_addr;
    logic [LA_W-1:0]            la_addr, lb_addr, ia_addr, ib_addr, w_addr;
    logic [2:0]                 m_row, m_col;
    logic signed [31:0]         m_value;

    // size register
    assign cfg_ready        = 1'b1;
    assign matrix_size_next = (cfg_valid && cfg_ready) ? cfg_data : matrix_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= 4'd4;
        end else begin
            matrix_size_reg <= matrix_size_next;
        end
    end

    spdinv_ctrl #(
        .MAX_DIM (MAX_DIM),
        .LA_W    (LA_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tlast     (s_tlast),
        .s_tready    (s_tready),
        .matrix_size (matrix_size_reg),
        .cmd         (cmd),
        .stat        (stat),
        .in_addr     (in_addr),
        .la_addr     (la_addr),
        .lb_addr     (lb_addr),
        .ia_addr     (ia_addr),
        .ib_addr     (ib_addr),
        .w_addr      (w_addr)
    );

    spdinv_dpath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS),
        .LA_W      (LA_W)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_addr  (in_addr),
        .la_addr  (la_addr),
        .lb_addr  (lb_addr),
        .ia_addr  (ia_addr),
        .ib_addr  (ib_addr),
        .w_addr   (w_addr),
        .in_data  ($signed(s_tdata)),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_row    (m_row),
        .m_col    (m_col),
        .m_value  (m_value),
        .m_last   (m_tlast),
        .m_err    (m_tuser)
    );

    // output packing
    assign m_tdata = {2'b00, m_value, m_col, m_row};

endmodule

[rtl/core/spdinv_iter.sv]
// spdinv_iter: shared iterative unit, rounded fixed-point divide and floor square root
// one quotient bit or one root bit per cycle
// depends on spdinv_pkg
`timescale 1ns / 1ps

module spdinv_iter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                div_start,
    input  logic                                sqrt_start,
    input  logic signed [spdinv_pkg::DATA_W-1:0] num,
    input  logic signed [spdinv_pkg::DATA_W-1:0] den,
    output logic                                busy,
    output logic signed [spdinv_pkg::DATA_W-1:0] result
);

    localparam int DIV_W = 33 + FRAC_BITS;
    localparam int RT_W  = (FRAC_BITS + 32) / 2;
    localparam int RAD_W = 2 * RT_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic               busy_reg, busy_next;
    logic               sqrt_mode_reg, sqrt_mode_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        den_reg, den_next;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [RT_W-1:0]    root_reg, root_next;
    logic [RT_W:0]      srem_reg, srem_next;

    logic [31:0]        num_mag;
    logic [32:0]        rem_sh;
    logic               div_ge;
    logic [RT_W+2:0]    srem_sh;
    logic [RT_W+2:0]    trial;
    logic               sqrt_ge;

    // magnitude of the numerator, most negative value maps to 2^31
    assign num_mag = num[31] ? 32'(-num) : 32'(num);

    assign rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge  = rem_sh >= {1'b0, den_reg};
    assign srem_sh = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = (RT_W+3)'({root_reg, 2'b01});
    assign sqrt_ge = srem_sh >= trial;

    // iteration control
    always_comb begin
        busy_next      = busy_reg;
        sqrt_mode_next = sqrt_mode_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        if (div_start) begin
            busy_next      = 1'b1;
            sqrt_mode_next = 1'b0;
            neg_next       = num[31];
            cnt_next       = CNT_W'(DIV_W);
            quo_next       = (DIV_W'(num_mag) << FRAC_BITS) + DIV_W'(den[31:1]);
            rem_next       = '0;
            den_next       = 32'(den);
        end else if (sqrt_start) begin
            busy_next      = 1'b1;
            sqrt_mode_next = 1'b1;
            cnt_next       = CNT_W'(RT_W);
            rad_next       = RAD_W'(num[30:0]) << FRAC_BITS;
            root_next      = '0;
            srem_next      = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
            if (sqrt_mode_reg) begin
                rad_next  = rad_reg << 2;
                root_next = {root_reg[RT_W-2:0], sqrt_ge};
                srem_next = sqrt_ge ? (RT_W+1)'(srem_sh - trial) : srem_sh[RT_W:0];
            end else begin
                quo_next = {quo_reg[DIV_W-2:0], div_ge};
                rem_next = div_ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        sqrt_mode_reg <= sqrt_mode_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        rad_reg       <= rad_next;
        root_reg      <= root_next;
        srem_reg      <= srem_next;
    end

    // signed, saturated quotient, or the root in square-root mode
    always_comb begin
        if (sqrt_mode_reg) begin
            result = 32'(root_reg);
        end else if (neg_reg) begin
            if (quo_reg > DIV_W'(33'h080000000)) begin
                result = 32'sh80000000;
            end else begin
                result = -$signed(quo_reg[31:0]);
            end
        end else begin
            if (quo_reg > DIV_W'(33'h07fffffff)) begin
                result = 32'sh7fffffff;
            end else begin
                result = $signed(quo_reg[31:0]);
            end
        end
    end

    assign busy = busy_reg;

endmodule

[rtl/core/spdinv_dpath.sv]
// spdinv_dpath: element store, factor and inverse-factor memories, multiply-accumulate,
// numerator register, divide / root unit and the result output register
// depends on spdinv_pkg and spdinv_iter
`timescale 1ns / 1ps

module spdinv_dpath #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16,
    parameter int LA_W      = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  spdinv_pkg::dp_cmd_t                  cmd,
    output spdinv_pkg::dp_stat_t                 stat,
    input  logic [spdinv_pkg::SLOT_W-1:0]        in_addr,
    input  logic [LA_W-1:0]                      la_addr,
    input  logic [LA_W-1:0]                      lb_addr,
    input  logic [LA_W-1:0]                      ia_addr,
    input  logic [LA_W-1:0]                      ib_addr,
    input  logic [LA_W-1:0]                      w_addr,
    input  logic signed [spdinv_pkg::DATA_W-1:0] in_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [spdinv_pkg::IDX_W-1:0]         m_row,
    output logic [spdinv_pkg::IDX_W-1:0]         m_col,
    output logic signed [spdinv_pkg::DATA_W-1:0] m_value,
    output logic                                 m_last,
    output logic                                 m_err
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ACC_W = 67 - FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] SAT_MAX = (ACC_W+1)'(64'sd2147483647);
    localparam logic signed [ACC_W:0] SAT_MIN = (ACC_W+1)'(-64'sd2147483648);

    logic signed [31:0] in_mem   [spdinv_pkg::SLOTS];
    logic signed [31:0] l_mem    [DEPTH];
    logic signed [31:0] linv_mem [DEPTH];

    logic signed [31:0] in_rd_reg, la_rd_reg, lb_rd_reg, ia_rd_reg, ib_rd_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg;
    logic signed [63:0] rounded;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0] num_reg, num_next;
    logic signed [31:0] den_reg;
    logic signed [31:0] unit_result;
    logic               unit_busy;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_row_reg, out_col_reg;
    logic               out_last_reg, out_err_reg;
    logic signed [31:0] out_value_reg;

    function automatic logic signed [31:0] sat32w(input logic signed [ACC_W:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    // element store
    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            in_mem[in_addr] <= in_data;
        end
        in_rd_reg <= in_mem[in_addr];
    end

    // lower factor memory, one write and two reads
    always_ff @(posedge aclk) begin
        if (cmd.l_we) begin
            l_mem[w_addr] <= unit_result;
        end
        la_rd_reg <= l_mem[la_addr];
        lb_rd_reg <= l_mem[lb_addr];
    end

    // inverse factor memory, one write and two reads
    always_ff @(posedge aclk) begin
        if (cmd.linv_we) begin
            linv_mem[w_addr] <= unit_result;
        end
        ia_rd_reg <= linv_mem[ia_addr];
        ib_rd_reg <= linv_mem[ib_addr];
    end

    // multiplier operand select
    always_comb begin
        case (cmd.mul_sel)
            spdinv_pkg::MUL_LL: begin
                mul_a = la_rd_reg;
                mul_b = lb_rd_reg;
            end
            spdinv_pkg::MUL_LI: begin
                mul_a = la_rd_reg;
                mul_b = ia_rd_reg;
            end
            spdinv_pkg::MUL_II: begin
                mul_a = ia_rd_reg;
                mul_b = ib_rd_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half away from zero: bias by half, or half minus one below zero
    assign rounded = (prod_reg + (prod_reg[63] ? (HALF - 64'sd1) : HALF)) >>> FRAC_BITS;
    assign term    = ACC_W'(rounded);

    // accumulator
    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_clr) begin
            acc_next = '0;
        end else if (cmd.acc_add) begin
            acc_next = acc_reg + term;
        end else if (cmd.acc_sub) begin
            acc_next = acc_reg - term;
        end
    end

    // numerator for the divide / root unit
    always_comb begin
        case (cmd.num_sel)
            spdinv_pkg::NUM_DIFF: num_next = sat32w((ACC_W+1)'(in_rd_reg)
                                                    - (ACC_W+1)'(acc_reg));
            spdinv_pkg::NUM_ACC:  num_next = sat32w((ACC_W+1)'(acc_reg));
            spdinv_pkg::NUM_ONE:  num_next = 32'(64'sd1 <<< FRAC_BITS);
            default:              num_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        acc_reg <= acc_next;
        if (cmd.num_en) begin
            num_reg <= num_next;
            den_reg <= la_rd_reg;
        end
    end

    spdinv_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .div_start  (cmd.div_start),
        .sqrt_start (cmd.sqrt_start),
        .num        (num_reg),
        .den        (den_reg),
        .busy       (unit_busy),
        .result     (unit_result)
    );

    // output register, holds a result until its transaction completes
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (cmd.out_load) begin
            out_row_reg   <= cmd.out_row;
            out_col_reg   <= cmd.out_col;
            out_last_reg  <= cmd.out_last;
            out_err_reg   <= cmd.out_err;
            out_value_reg <= cmd.out_err ? 32'sd0 : sat32w((ACC_W+1)'(acc_reg));
        end
    end

    assign stat.unit_busy  = unit_busy;
    assign stat.num_nonpos = (num_reg[31] || (num_reg == 32'sd0));
    assign stat.out_full   = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_row   = out_row_reg;
    assign m_col   = out_col_reg;
    assign m_value = out_value_reg;
    assign m_last  = out_last_reg;
    assign m_err   = out_err_reg;

endmodule

[rtl/core/spdinv_ctrl.sv]
// spdinv_ctrl: sequencer for loading, cholesky factoring, forward substitution and
// the product pass, loop counters and memory addresses
// depends on spdinv_pkg
`timescale 1ns / 1ps

module spdinv_ctrl #(
    parameter int MAX_DIM = 8,
    parameter int LA_W    = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tlast,
    output logic                              s_tready,
    input  logic [spdinv_pkg::SIZE_W-1:0]     matrix_size,
    output spdinv_pkg::dp_cmd_t               cmd,
    input  spdinv_pkg::dp_stat_t              stat,
    output logic [spdinv_pkg::SLOT_W-1:0]     in_addr,
    output logic [LA_W-1:0]                   la_addr,
    output logic [LA_W-1:0]                   lb_addr,
    output logic [LA_W-1:0]                   ia_addr,
    output logic [LA_W-1:0]                   ib_addr,
    output logic [LA_W-1:0]                   w_addr
);

    spdinv_pkg::state_t state_reg, state_next;

    logic [2:0] i_reg, i_next;
    logic [2:0] j_reg, j_next;
    logic [2:0] k_reg, k_next;
    logic [3:0] n_reg, n_next;
    logic [5:0] pos_reg, pos_next;
    logic       err_reg, err_next;
    logic [3:0] eff_size;
    logic [2:0] nm1;
    logic [2:0] kmax;
    logic       diag;

    function automatic logic [LA_W-1:0] rc(input logic [2:0] r, input logic [2:0] c);
        return LA_W'(32'(r) * MAX_DIM + 32'(c));
    endfunction

    // size register clamped into one to the largest dimension
    always_comb begin
        if (matrix_size == 4'd0) begin
            eff_size = 4'd1;
        end else if (matrix_size > 4'(MAX_DIM)) begin
            eff_size = 4'(MAX_DIM);
        end else begin
            eff_size = matrix_size;
        end
    end

    assign nm1  = 3'(n_reg - 4'd1);
    assign kmax = (i_reg > j_reg) ? i_reg : j_reg;
    assign diag = (i_reg == j_reg);

    // next state and loop counters
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        case (state_reg)
            spdinv_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    pos_next = pos_reg + 6'd1;
                    if (s_tlast) begin
                        pos_next   = '0;
                        n_next     = eff_size;
                        i_next     = '0;
                        j_next     = '0;
                        err_next   = 1'b0;
                        state_next = spdinv_pkg::ST_F_START;
                    end
                end
            end
            spdinv_pkg::ST_F_START: begin
                k_next     = '0;
                state_next = (j_reg == 3'd0) ? spdinv_pkg::ST_F_DEN : spdinv_pkg::ST_F_RD;
            end
            spdinv_pkg::ST_F_RD:  state_next = spdinv_pkg::ST_F_MUL;
            spdinv_pkg::ST_F_MUL: state_next = spdinv_pkg::ST_F_ACC;
            spdinv_pkg::ST_F_ACC: begin
                k_next     = k_reg + 3'd1;
                state_next = ({1'b0, k_reg} + 4'd1 < {1'b0, j_reg}) ?
                             spdinv_pkg::ST_F_RD : spdinv_pkg::ST_F_DEN;
            end
            spdinv_pkg::ST_F_DEN: state_next = spdinv_pkg::ST_F_NUM;
            spdinv_pkg::ST_F_NUM: state_next = spdinv_pkg::ST_F_CHK;
            spdinv_pkg::ST_F_CHK: begin
                if (diag && stat.num_nonpos) begin
                    err_next   = 1'b1;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = spdinv_pkg::ST_O_START;
                end else begin
                    state_next = spdinv_pkg::ST_F_WAIT;
                end
            end
            spdinv_pkg::ST_F_WAIT: begin
                if (!stat.unit_busy) begin
                    if (j_reg < i_reg) begin
                        j_next     = j_reg + 3'd1;
                        state_next = spdinv_pkg::ST_F_START;
                    end else if (i_reg < nm1) begin
                        i_next     = i_reg + 3'd1;
                        j_next     = '0;
                        state_next = spdinv_pkg::ST_F_START;
                    end else begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = spdinv_pkg::ST_V_START;
                    end
                end
            end
            spdinv_pkg::ST_V_START: begin
                k_next     = i_reg;
                state_next = (i_reg < j_reg) ? spdinv_pkg::ST_V_RD : spdinv_pkg::ST_V_DEN;
            end
            spdinv_pkg::ST_V_RD:  state_next = spdinv_pkg::ST_V_MUL;
            spdinv_pkg::ST_V_MUL: state_next = spdinv_pkg::ST_V_ACC;
            spdinv_pkg::ST_V_ACC: begin
                k_next     = k_reg + 3'd1;
                state_next = ({1'b0, k_reg} + 4'd1 < {1'b0, j_reg}) ?
                             spdinv_pkg::ST_V_RD : spdinv_pkg::ST_V_DEN;
            end
            spdinv_pkg::ST_V_DEN: state_next = spdinv_pkg::ST_V_NUM;
            spdinv_pkg::ST_V_NUM: state_next = spdinv_pkg::ST_V_CHK;
            spdinv_pkg::ST_V_CHK: state_next = spdinv_pkg::ST_V_WAIT;
            spdinv_pkg::ST_V_WAIT: begin
                if (!stat.unit_busy) begin
                    if (j_reg < nm1) begin
                        j_next     = j_reg + 3'd1;
                        state_next = spdinv_pkg::ST_V_START;
                    end else if (i_reg < nm1) begin
                        i_next     = i_reg + 3'd1;
                        j_next     = i_reg + 3'd1;
                        state_next = spdinv_pkg::ST_V_START;
                    end else begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = spdinv_pkg::ST_O_START;
                    end
                end
            end
            spdinv_pkg::ST_O_START: begin
                k_next     = kmax;
                state_next = err_reg ? spdinv_pkg::ST_O_EMIT : spdinv_pkg::ST_O_RD;
            end
            spdinv_pkg::ST_O_RD:  state_next = spdinv_pkg::ST_O_MUL;
            spdinv_pkg::ST_O_MUL: state_next = spdinv_pkg::ST_O_ACC;
            spdinv_pkg::ST_O_ACC: begin
                k_next     = k_reg + 3'd1;
                state_next = (k_reg < nm1) ? spdinv_pkg::ST_O_RD : spdinv_pkg::ST_O_EMIT;
            end
            spdinv_pkg::ST_O_EMIT: begin
                if (!stat.out_full) begin
                    if (j_reg < nm1) begin
                        j_next     = j_reg + 3'd1;
                        state_next = spdinv_pkg::ST_O_START;
                    end else if (i_reg < nm1) begin
                        i_next     = i_reg + 3'd1;
                        j_next     = '0;
                        state_next = spdinv_pkg::ST_O_START;
                    end else begin
                        state_next = spdinv_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = spdinv_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        cmd.out_row  = i_reg;
        cmd.out_col  = j_reg;
        cmd.out_last = (i_reg == nm1) && (j_reg == nm1);
        cmd.out_err  = err_reg;
        case (state_reg)
            spdinv_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_we = s_tvalid;
            end
            spdinv_pkg::ST_F_START, spdinv_pkg::ST_V_START, spdinv_pkg::ST_O_START: begin
                cmd.acc_clr = 1'b1;
            end
            spdinv_pkg::ST_F_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = spdinv_pkg::MUL_LL;
            end
            spdinv_pkg::ST_V_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = spdinv_pkg::MUL_LI;
            end
            spdinv_pkg::ST_O_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = spdinv_pkg::MUL_II;
            end
            spdinv_pkg::ST_F_ACC, spdinv_pkg::ST_O_ACC: cmd.acc_add = 1'b1;
            spdinv_pkg::ST_V_ACC: cmd.acc_sub = 1'b1;
            spdinv_pkg::ST_F_NUM: begin
                cmd.num_en  = 1'b1;
                cmd.num_sel = spdinv_pkg::NUM_DIFF;
            end
            spdinv_pkg::ST_V_NUM: begin
                cmd.num_en  = 1'b1;
                cmd.num_sel = diag ? spdinv_pkg::NUM_ONE : spdinv_pkg::NUM_ACC;
            end
            spdinv_pkg::ST_F_CHK: begin
                cmd.sqrt_start = diag && !stat.num_nonpos;
                cmd.div_start  = !diag;
            end
            spdinv_pkg::ST_V_CHK:  cmd.div_start = 1'b1;
            spdinv_pkg::ST_F_WAIT: cmd.l_we      = !stat.unit_busy;
            spdinv_pkg::ST_V_WAIT: cmd.linv_we   = !stat.unit_busy;
            spdinv_pkg::ST_O_EMIT: cmd.out_load  = !stat.out_full;
            default: begin
                cmd = '0;
            end
        endcase
    end

    // memory addresses
    always_comb begin
        in_addr = (state_reg == spdinv_pkg::ST_IDLE) ? pos_reg :
                  ({3'b0, i_reg} * {2'b0, n_reg} + {3'b0, j_reg});
        lb_addr = rc(j_reg, k_reg);
        ia_addr = rc(k_reg, i_reg);
        ib_addr = rc(k_reg, j_reg);
        case (state_reg)
            spdinv_pkg::ST_F_RD: la_addr = rc(i_reg, k_reg);
            spdinv_pkg::ST_V_RD: la_addr = rc(j_reg, k_reg);
            default:             la_addr = rc(j_reg, j_reg);
        endcase
        case (state_reg)
            spdinv_pkg::ST_V_WAIT: w_addr = rc(j_reg, i_reg);
            default:               w_addr = rc(i_reg, j_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spdinv_pkg::ST_IDLE;
            pos_reg   <= '0;
            err_reg   <= 1'b0;
            n_reg     <= 4'd1;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
            n_reg     <= n_next;
        end
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    // a result is never loaded over one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.out_full)
        else $error("result loaded while output register full");

    // the shared unit is started only when free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_start || cmd.sqrt_start) |-> !stat.unit_busy)
        else $error("divide / root unit started while busy");

    // a started operation shows busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_start || cmd.sqrt_start) |=> stat.unit_busy)
        else $error("divide / root unit did not start");

    // factor memories and the output register are never written while elements load
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_we |-> !(cmd.l_we || cmd.linv_we || cmd.out_load))
        else $error("compute write during element load");

endmodule
